/* design/lps_pkg.sv */
// Shared types for the longest palindromic substring block.
package lps_pkg;

    localparam int START_W  = 6;
    localparam int LENGTH_W = 7;

    typedef logic [7:0] t_byte;

    typedef struct packed {
        logic take;
        logic last;
    } t_step;

    typedef struct packed {
        logic store;
        logic clear;
    } t_cell_ctl;

endpackage

/* design/lps_cell.sv */
// One character cell: stored byte and palindromic-suffix flag for its start index.
module lps_cell #(
    parameter int K  = 0,
    parameter int CW = 7
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  lps_pkg::t_cell_ctl i_ctl,
    input  logic [CW-1:0]     i_count,
    input  lps_pkg::t_byte    i_ch,
    input  logic              i_pal_nb,
    output logic              o_pal,
    output logic              o_pal_new
);
    import lps_pkg::*;

    t_byte r_byte;
    logic  r_pal;
    logic  r_used;
    logic  sel;

    assign sel       = (i_count == CW'(K));
    assign o_pal     = r_used ? r_pal : 1'b1;
    assign o_pal_new = sel | ((r_byte == i_ch) & i_pal_nb);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= 1'b0;
        end else if (i_ctl.clear) begin
            r_used <= 1'b0;
        end else if (i_ctl.store && sel) begin
            r_used <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.store) begin
            r_pal <= o_pal_new;
        end
        if (i_ctl.store && sel) begin
            r_byte <= i_ch;
        end
    end

endmodule

/* design/lps_track.sv */
// Fill count, overflow flag and running best palindrome of the current string.
module lps_track #(
    parameter int MAX_LEN = 64,
    parameter int IW      = 6,
    parameter int CW      = 7
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  lps_pkg::t_step     i_step,
    input  logic [MAX_LEN-1:0] i_pal_new,
    output lps_pkg::t_cell_ctl o_ctl,
    output logic [CW-1:0]      o_count,
    output logic [IW-1:0]      o_res_begin,
    output logic [CW-1:0]      o_res_len,
    output logic               o_res_over
);
    import lps_pkg::*;

    logic [CW-1:0] r_count;
    logic [CW-1:0] r_best_len;
    logic [IW-1:0] r_best_begin;
    logic          r_over;

    logic          store;
    logic [CW-1:0] d1;
    logic [IW-1:0] d1i;
    logic [IW-1:0] d2i;
    logic          hit1;
    logic          hit2;
    logic [CW-1:0] n_best_len;
    logic [IW-1:0] n_best_begin;
    logic          n_over;

    assign store = i_step.take & (r_count < CW'(MAX_LEN));
    assign d1    = r_count - r_best_len;
    assign d1i   = d1[IW-1:0];
    assign d2i   = d1i - IW'(1);
    // suffix length grows by at most two per byte
    assign hit2  = store & (d1 != '0) & i_pal_new[d2i];
    assign hit1  = store & i_pal_new[d1i];

    always_comb begin
        n_best_len   = r_best_len;
        n_best_begin = r_best_begin;
        if (hit2) begin
            n_best_len   = r_best_len + CW'(2);
            n_best_begin = d2i;
        end else if (hit1) begin
            n_best_len   = r_best_len + CW'(1);
            n_best_begin = d1i;
        end
    end

    assign n_over = r_over | (i_step.take & ~store);

    assign o_ctl.store = store;
    assign o_ctl.clear = i_step.take & i_step.last;
    assign o_count     = r_count;
    assign o_res_begin = n_best_begin;
    assign o_res_len   = n_best_len;
    assign o_res_over  = n_over;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count      <= '0;
            r_best_len   <= '0;
            r_best_begin <= '0;
            r_over       <= 1'b0;
        end else if (i_step.take) begin
            if (i_step.last) begin
                r_count      <= '0;
                r_best_len   <= '0;
                r_best_begin <= '0;
                r_over       <= 1'b0;
            end else begin
                r_count      <= r_count + CW'(store);
                r_best_len   <= n_best_len;
                r_best_begin <= n_best_begin;
                r_over       <= n_over;
            end
        end
    end

endmodule

/* design/longest_palindromic_substring.sv */
// Top level: streaming longest palindromic substring finder over a chain of byte cells.
//
//  channel  dir  handshake          word
//  input    in   i_valid/o_stall    i_ch, i_last
//  output   out  o_valid/i_stall    o_best_start, o_best_length, o_overflow
//
//  One byte per cycle while o_stall is low; each cell updates its suffix flag from its neighbor on each stored byte.
//  The result is registered into the output register in the cycle after the final byte is taken.
//  Reset clears cell valid bits, counters and the output valid flag.
//  Only a final byte is stalled, and only while a result is held and i_stall is high.
module longest_palindromic_substring #(
    parameter int MAX_LEN = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  lps_pkg::t_byte                i_ch,
    input  logic                          i_last,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [lps_pkg::START_W-1:0]   o_best_start,
    output logic [lps_pkg::LENGTH_W-1:0]  o_best_length,
    output logic                          o_overflow
);
    import lps_pkg::*;

    localparam int IW = $clog2(MAX_LEN);
    localparam int CW = $clog2(MAX_LEN + 1);

    t_step              step;
    t_cell_ctl          ctl;
    logic [CW-1:0]      count;
    logic [MAX_LEN-1:0] pal_cur;
    logic [MAX_LEN-1:0] pal_new;
    logic [IW-1:0]      res_begin;
    logic [CW-1:0]      res_len;
    logic               res_over;

    logic               r_out_valid;
    logic [IW-1:0]      r_begin;
    logic [CW-1:0]      r_len;
    logic               r_over;

    assign o_stall   = i_last & r_out_valid & i_stall;
    assign step.take = i_valid & ~o_stall;
    assign step.last = i_last;

    genvar k;
    generate
        for (k = 0; k < MAX_LEN; k++) begin : g_cell
            logic pal_nb;
            if (k == MAX_LEN - 1) begin : g_end
                assign pal_nb = 1'b1;
            end else begin : g_mid
                assign pal_nb = pal_cur[k+1];
            end
            lps_cell #(
                .K  (k),
                .CW (CW)
            ) u_cell (
                .i_clk     (i_clk),
                .i_rst_n   (i_rst_n),
                .i_ctl     (ctl),
                .i_count   (count),
                .i_ch      (i_ch),
                .i_pal_nb  (pal_nb),
                .o_pal     (pal_cur[k]),
                .o_pal_new (pal_new[k])
            );
        end
    endgenerate

    lps_track #(
        .MAX_LEN (MAX_LEN),
        .IW      (IW),
        .CW      (CW)
    ) u_track (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_pal_new   (pal_new),
        .o_ctl       (ctl),
        .o_count     (count),
        .o_res_begin (res_begin),
        .o_res_len   (res_len),
        .o_res_over  (res_over)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step.take && step.last) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step.take && step.last) begin
            r_begin <= res_begin;
            r_len   <= res_len;
            r_over  <= res_over;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_best_start  = START_W'(r_begin);
    assign o_best_length = LENGTH_W'(r_len);
    assign o_overflow    = r_over;

`ifndef NO_ASSERTIONS
    a_rise_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(step.take && step.last))
        else $error("result raised without a final byte");

    a_len_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (r_len != '0) && ({1'b0, r_len} <= (CW+1)'(MAX_LEN)))
        else $error("result length out of range");

    a_span_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((CW+1)'(r_begin) + (CW+1)'(r_len) <= (CW+1)'(MAX_LEN)))
        else $error("palindrome runs past the store");

    a_over_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (step.take && !ctl.store) |-> (count == CW'(MAX_LEN)))
        else $error("byte dropped with room in the store");
`endif

endmodule

/* sim/longest_palindromic_substring_tb.sv */
// Testbench for longest_palindromic_substring: directed and random strings, brute-force check.
`timescale 1ns / 1ps

module longest_palindromic_substring_tb;
    import lps_pkg::*;

    localparam int MAX_LEN = 64;

    typedef t_byte t_text[$];

    typedef struct packed {
        logic [START_W-1:0]  start;
        logic [LENGTH_W-1:0] length;
        logic                ovf;
    } t_answer;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_valid = 1'b0;
    logic                o_stall;
    t_byte               i_ch = '0;
    logic                i_last = 1'b0;
    logic                o_valid;
    logic                i_stall = 1'b0;
    logic [START_W-1:0]  o_best_start;
    logic [LENGTH_W-1:0] o_best_length;
    logic                o_overflow;

    t_byte   text_buf [MAX_LEN];
    int      n_stored = 0;
    logic    dropped = 1'b0;
    t_answer pending_answers[$];
    t_answer want;

    int error_count = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_request = 0;
    int hold_left = 0;

    longest_palindromic_substring #(.MAX_LEN(MAX_LEN)) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_ch          (i_ch),
        .i_last        (i_last),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_best_start  (o_best_start),
        .o_best_length (o_best_length),
        .o_overflow    (o_overflow)
    );

    always #5 i_clk = ~i_clk;

    // longest mirrored run, earliest start on ties
    function automatic t_answer longest_run(int n);
        t_answer a;
        int      len;
        int      st;
        int      k;
        bit      ok;
        bit      found;
        a = '0;
        a.length = LENGTH_W'(1);
        found = 1'b0;
        for (len = n; len >= 2 && !found; len--) begin
            for (st = 0; st + len <= n && !found; st++) begin
                ok = 1'b1;
                for (k = 0; k < len / 2; k++) begin
                    if (text_buf[st + k] != text_buf[st + len - 1 - k]) ok = 1'b0;
                end
                if (ok) begin
                    a.start = st[START_W-1:0];
                    a.length = len[LENGTH_W-1:0];
                    found = 1'b1;
                end
            end
        end
        return a;
    endfunction

    task automatic absorb_byte(input t_byte ch, input logic last);
        t_answer a;
        if (n_stored < MAX_LEN) begin
            text_buf[n_stored] = ch;
            n_stored++;
        end else begin
            dropped = 1'b1;
        end
        if (last) begin
            a = longest_run(n_stored);
            a.ovf = dropped;
            pending_answers.push_back(a);
            n_stored = 0;
            dropped = 1'b0;
        end
    endtask

    // called at a falling edge; returns at the falling edge after the word is taken
    task automatic send_byte(input t_byte ch, input logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_valid = 1'b1;
        i_ch = ch;
        i_last = last;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        absorb_byte(ch, last);
        @(negedge i_clk);
    endtask

    task automatic send_text(input t_text text);
        for (int i = 0; i < text.size(); i++) send_byte(text[i], i == text.size() - 1);
        i_valid = 1'b0;
    endtask

    function automatic t_text from_ascii(string s);
        t_text t;
        for (int i = 0; i < s.len(); i++) t.push_back(t_byte'(s[i]));
        return t;
    endfunction

    function automatic t_text random_text(int len);
        t_text t;
        int    kind;
        t_byte base;
        t_byte flip;
        int    pal_len;
        int    pal_at;
        kind = $urandom_range(2);
        base = t_byte'($urandom);
        flip = t_byte'($urandom_range(1, 255));
        for (int i = 0; i < len; i++) begin
            if (kind == 1) t.push_back(t_byte'($urandom));
            else t.push_back($urandom_range(1) ? base : base ^ flip);
        end
        // plant a mirrored run
        if (kind == 2 && len >= 2) begin
            pal_len = $urandom_range(2, len);
            pal_at = $urandom_range(0, len - pal_len);
            for (int k = 0; k < pal_len / 2; k++) begin
                t[pal_at + k] = t_byte'($urandom);
                t[pal_at + pal_len - 1 - k] = t[pal_at + k];
            end
        end
        return t;
    endfunction

    function automatic int random_len();
        int r;
        r = $urandom_range(99);
        if (r < 70) return $urandom_range(1, 12);
        if (r < 95) return $urandom_range(13, MAX_LEN);
        return $urandom_range(MAX_LEN + 1, MAX_LEN + 8);
    endfunction

    always @(negedge i_clk) begin
        if (hold_request > 0) begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            i_stall = 1'b1;
            hold_left--;
        end else begin
            i_stall = ($urandom_range(99) < recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_answers.size() == 0) begin
                $display("%0t: unexpected word start=%0d length=%0d overflow=%0b",
                         $time, o_best_start, o_best_length, o_overflow);
                error_count++;
            end else begin
                want = pending_answers.pop_front();
                if (o_best_start !== want.start) begin
                    $display("%0t: best_start expected %0d actual %0d",
                             $time, want.start, o_best_start);
                    error_count++;
                end
                if (o_best_length !== want.length) begin
                    $display("%0t: best_length expected %0d actual %0d",
                             $time, want.length, o_best_length);
                    error_count++;
                end
                if (o_overflow !== want.ovf) begin
                    $display("%0t: overflow expected %0b actual %0b",
                             $time, want.ovf, o_overflow);
                    error_count++;
                end
            end
        end
    end

    task automatic test_single_bytes();
        t_text t;
        t.push_back(8'h00);
        send_text(t);
        t[0] = 8'hFF;
        send_text(t);
        t[0] = 8'h5A;
        send_text(t);
    endtask

    task automatic test_even_odd();
        send_text(from_ascii("abba"));
        send_text(from_ascii("xabcba"));
    endtask

    task automatic test_ties();
        send_text(from_ascii("abcd"));
        send_text(from_ascii("abacdc"));
        send_text(from_ascii("zz"));
    endtask

    task automatic test_capacity();
        t_text t;
        for (int i = 0; i < MAX_LEN; i++) t.push_back(8'h61);
        send_text(t);
        send_text(random_text(MAX_LEN + 2));
        t = random_text(MAX_LEN);
        t.push_back(8'hA5);
        send_text(t);
    endtask

    // long receiver hold while short strings keep coming
    task automatic test_pressure();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_request = 300;
        for (int i = 0; i < 40; i++) send_text(random_text($urandom_range(1, 3)));
    endtask

    task automatic test_random(input int n_items, input int send_pct, input int recv_pct);
        int    sent;
        t_text t;
        send_idle_pct = send_pct;
        recv_stall_pct = recv_pct;
        sent = 0;
        while (sent < n_items) begin
            t = random_text(random_len());
            send_text(t);
            sent += t.size();
        end
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);
        test_single_bytes();
        test_even_odd();
        test_ties();
        test_capacity();
        test_pressure();
        test_random(180, 0, 0);
        test_random(180, 80, 0);
        test_random(180, 0, 80);
        test_random(180, 21, 21);
        wait (pending_answers.size() == 0);
        repeat (10) @(posedge i_clk);
        if (error_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule
